// ===== design/sppm_pkg.sv =====
// sppm_pkg: sizes, opcodes, controller states and the term record shared by
// the sparse polynomial multiplier, its channel interfaces and its cells.
// No dependencies.
package sppm_pkg;

  localparam int FIRST_TERMS   = 8;
  localparam int SECOND_TERMS  = 8;
  localparam int PRODUCT_TERMS = 64;

  localparam int OPCODE_W    = 2;
  localparam int TERM_POW_W  = 7;
  localparam int TERM_COEF_W = 16;
  localparam int OUT_POW_W   = 8;
  localparam int OUT_COEF_W  = 38;
  localparam int PROD_W      = 2 * TERM_COEF_W;

  localparam int A_CNT_W = $clog2(FIRST_TERMS + 1);
  localparam int B_CNT_W = $clog2(SECOND_TERMS + 1);
  localparam int A_IDX_W = (FIRST_TERMS > 1) ? $clog2(FIRST_TERMS) : 1;
  localparam int B_IDX_W = (SECOND_TERMS > 1) ? $clog2(SECOND_TERMS) : 1;

  // cycles from the last issued pair until the chain holds no token
  localparam int FLUSH_CYCLES = PRODUCT_TERMS + 3;
  localparam int FLUSH_W      = $clog2(FLUSH_CYCLES);

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD_FIRST  = 2'd0,
    OP_LOAD_SECOND = 2'd1,
    OP_MULTIPLY    = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_FLUSH,
    ST_DRAIN,
    ST_EMPTY
  } state_e;

  // product token traveling down the chain, and the entry a cell holds
  typedef struct packed {
    logic                         valid;
    logic [OUT_POW_W-1:0]         power;
    logic signed [OUT_COEF_W-1:0] coef;
  } term_t;

endpackage

// ===== design/sppm_if.sv =====
// sppm_in_if and sppm_out_if: valid/ready channels of the sparse polynomial
// multiplier, one for requests and one for result terms.
// Depends on sppm_pkg.
interface sppm_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [sppm_pkg::OPCODE_W-1:0]           opcode;
  logic [sppm_pkg::TERM_POW_W-1:0]         term_power;
  logic signed [sppm_pkg::TERM_COEF_W-1:0] term_coefficient;

  modport source (output valid, output opcode, output term_power, output term_coefficient,
                  input ready);
  modport sink (input valid, input opcode, input term_power, input term_coefficient,
                output ready);
endinterface

interface sppm_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [sppm_pkg::OUT_POW_W-1:0]         out_power;
  logic signed [sppm_pkg::OUT_COEF_W-1:0] out_coefficient;
  logic                                   last_term;
  logic                                   empty_product;
  logic                                   terms_dropped;

  modport source (output valid, output out_power, output out_coefficient,
                  output last_term, output empty_product, output terms_dropped,
                  input ready);
  modport sink (input valid, input out_power, input out_coefficient,
                input last_term, input empty_product, input terms_dropped,
                output ready);
endinterface

// ===== design/sppm_cell.sv =====
// sppm_cell: one entry of the product table. Merges a passing token of equal
// power, claims a token when empty, else forwards it; shifts entries on drain.
// Depends on sppm_pkg.
module sppm_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  sppm_pkg::term_t tok_i,
  input  sppm_pkg::term_t ent_i,
  output sppm_pkg::term_t tok_o,
  output sppm_pkg::term_t ent_o
);
  import sppm_pkg::*;

  term_t ent_q, ent_d;
  term_t tok_q, tok_d;
  logic  match;
  logic  claim;

  always_comb begin
    match       = tok_i.valid && ent_q.valid && (ent_q.power == tok_i.power);
    claim       = tok_i.valid && !ent_q.valid;
    ent_d       = ent_q;
    tok_d       = tok_i;
    tok_d.valid = tok_i.valid && !match && !claim;
    priority if (shift_i) begin
      ent_d       = ent_i;
      tok_d.valid = 1'b0;
    end else if (match) begin
      ent_d.coef = ent_q.coef + tok_i.coef;
    end else if (claim) begin
      ent_d = tok_i;
    end else begin
      ent_d = ent_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
      tok_q <= '0;
    end else begin
      ent_q <= ent_d;
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;
  assign ent_o = ent_q;

endmodule

// ===== design/sparse_polynomial_multiply.sv =====
// sparse_polynomial_multiply: top level, term stores, pair issue, multiplier
// stage, the chain of product cells and the result register.
// Depends on sppm_pkg, sppm_if.sv and sppm_cell.
//
// A multiply request streams every pair of stored terms, one pair a cycle,
// through a registered 16x16 multiplier into a chain of PRODUCT_TERMS cells;
// each product moves one cell a cycle until it merges with the entry of equal
// power or opens the first free cell. After the chain empties the entries
// shift toward the last cell, which feeds the result register, so results
// leave newest power first. A multiply with an empty polynomial skips the
// chain. Requests are accepted only between multiplies.
module sparse_polynomial_multiply (
  input logic        clk_i,
  input logic        rst_ni,
  sppm_in_if.sink    in_i,
  sppm_out_if.source out_o
);
  import sppm_pkg::*;

  state_e state_q, state_d;

  logic [A_CNT_W-1:0]            a_cnt_q;
  logic [B_CNT_W-1:0]            b_cnt_q;
  logic [TERM_POW_W-1:0]         a_pow_q  [FIRST_TERMS];
  logic signed [TERM_COEF_W-1:0] a_coef_q [FIRST_TERMS];
  logic [TERM_POW_W-1:0]         b_pow_q  [SECOND_TERMS];
  logic signed [TERM_COEF_W-1:0] b_coef_q [SECOND_TERMS];
  logic [A_IDX_W-1:0]            a_idx_q;
  logic [B_IDX_W-1:0]            b_idx_q;
  logic                          ovf_q;
  logic [FLUSH_W-1:0]            flush_q;

  logic                          s1_vq;
  logic [OUT_POW_W-1:0]          s1_pow_q;
  logic signed [TERM_COEF_W-1:0] s1_a_coef_q;
  logic signed [TERM_COEF_W-1:0] s1_b_coef_q;
  logic signed [PROD_W-1:0]      prod;
  term_t                         head_q;

  term_t tok [PRODUCT_TERMS+1];
  term_t ent [PRODUCT_TERMS+1];
  logic  lower_valid;
  logic  any_valid;

  logic                         out_vq;
  logic [OUT_POW_W-1:0]         out_pow_q;
  logic signed [OUT_COEF_W-1:0] out_coef_q;
  logic                         out_last_q;
  logic                         out_empty_q;
  logic                         out_drop_q;
  logic                         out_free;

  logic in_ready;
  logic accept;
  logic is_load_a;
  logic is_load_b;
  logic is_mult;
  logic a_full;
  logic b_full;
  logic a_last;
  logic b_last;
  logic no_terms;
  logic flush_done;
  logic issue;
  logic shift;
  logic take;
  logic emit_empty;
  logic clear_all;

  assign accept     = in_i.valid && in_ready;
  assign is_load_a  = accept && (in_i.opcode == OP_LOAD_FIRST);
  assign is_load_b  = accept && (in_i.opcode == OP_LOAD_SECOND);
  assign is_mult    = accept && (in_i.opcode == OP_MULTIPLY);
  assign a_full     = (a_cnt_q == A_CNT_W'(FIRST_TERMS));
  assign b_full     = (b_cnt_q == B_CNT_W'(SECOND_TERMS));
  assign a_last     = (A_CNT_W'(a_idx_q) == a_cnt_q - A_CNT_W'(1));
  assign b_last     = (B_CNT_W'(b_idx_q) == b_cnt_q - B_CNT_W'(1));
  assign no_terms   = (a_cnt_q == '0) || (b_cnt_q == '0);
  assign flush_done = (flush_q == FLUSH_W'(FLUSH_CYCLES - 1));
  assign out_free   = !out_vq || out_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (is_mult) state_d = no_terms ? ST_EMPTY : ST_ISSUE;
      ST_ISSUE: if (a_last && b_last) state_d = ST_FLUSH;
      ST_FLUSH: if (flush_done) state_d = ST_DRAIN;
      ST_DRAIN: if (!any_valid) state_d = ST_IDLE;
      ST_EMPTY: if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    in_ready   = 1'b0;
    issue      = 1'b0;
    shift      = 1'b0;
    take       = 1'b0;
    emit_empty = 1'b0;
    clear_all  = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_ready = 1'b1;
      ST_ISSUE: issue = 1'b1;
      ST_FLUSH: ;
      ST_DRAIN: begin
        take      = ent[PRODUCT_TERMS].valid && out_free;
        shift     = !ent[PRODUCT_TERMS].valid || out_free;
        clear_all = !any_valid;
      end
      ST_EMPTY: begin
        emit_empty = out_free;
        clear_all  = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // term stores
  always_ff @(posedge clk_i) begin
    if (is_load_a && !a_full) begin
      a_pow_q[a_cnt_q[A_IDX_W-1:0]]  <= in_i.term_power;
      a_coef_q[a_cnt_q[A_IDX_W-1:0]] <= in_i.term_coefficient;
    end
    if (is_load_b && !b_full) begin
      b_pow_q[b_cnt_q[B_IDX_W-1:0]]  <= in_i.term_power;
      b_coef_q[b_cnt_q[B_IDX_W-1:0]] <= in_i.term_coefficient;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_cnt_q <= '0;
      b_cnt_q <= '0;
      ovf_q   <= 1'b0;
    end else if (clear_all) begin
      a_cnt_q <= '0;
      b_cnt_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      if (is_load_a && !a_full) a_cnt_q <= a_cnt_q + A_CNT_W'(1);
      if (is_load_b && !b_full) b_cnt_q <= b_cnt_q + B_CNT_W'(1);
      if ((is_load_a && a_full) || (is_load_b && b_full) || tok[PRODUCT_TERMS].valid) begin
        ovf_q <= 1'b1;
      end
    end
  end

  // pair issue, first polynomial outer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_idx_q <= '0;
      b_idx_q <= '0;
      flush_q <= '0;
      s1_vq   <= 1'b0;
    end else begin
      s1_vq   <= issue;
      flush_q <= (state_q == ST_FLUSH) ? flush_q + FLUSH_W'(1) : '0;
      if (is_mult) begin
        a_idx_q <= '0;
        b_idx_q <= '0;
      end else if (issue) begin
        if (b_last) begin
          b_idx_q <= '0;
          a_idx_q <= a_idx_q + A_IDX_W'(1);
        end else begin
          b_idx_q <= b_idx_q + B_IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_pow_q    <= OUT_POW_W'(a_pow_q[a_idx_q]) + OUT_POW_W'(b_pow_q[b_idx_q]);
    s1_a_coef_q <= a_coef_q[a_idx_q];
    s1_b_coef_q <= b_coef_q[b_idx_q];
  end

  assign prod = s1_a_coef_q * s1_b_coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else begin
      head_q.valid <= s1_vq;
      head_q.power <= s1_pow_q;
      head_q.coef  <= {{(OUT_COEF_W - PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  // product table as a chain of cells
  assign tok[0] = head_q;
  assign ent[0] = '0;

  for (genvar k = 0; k < PRODUCT_TERMS; k++) begin : g_cell
    sppm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .tok_i   (tok[k]),
      .ent_i   (ent[k]),
      .tok_o   (tok[k+1]),
      .ent_o   (ent[k+1])
    );
  end

  always_comb begin
    lower_valid = 1'b0;
    for (int k = 1; k < PRODUCT_TERMS; k++) begin
      lower_valid = lower_valid | ent[k].valid;
    end
    any_valid = lower_valid | ent[PRODUCT_TERMS].valid;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq      <= 1'b0;
      out_pow_q   <= '0;
      out_coef_q  <= '0;
      out_last_q  <= 1'b0;
      out_empty_q <= 1'b0;
      out_drop_q  <= 1'b0;
    end else if (take) begin
      out_vq      <= 1'b1;
      out_pow_q   <= ent[PRODUCT_TERMS].power;
      out_coef_q  <= ent[PRODUCT_TERMS].coef;
      out_last_q  <= !lower_valid;
      out_empty_q <= 1'b0;
      out_drop_q  <= ovf_q;
    end else if (emit_empty) begin
      out_vq      <= 1'b1;
      out_pow_q   <= '0;
      out_coef_q  <= '0;
      out_last_q  <= 1'b0;
      out_empty_q <= 1'b1;
      out_drop_q  <= 1'b0;
    end else if (out_o.ready) begin
      out_vq <= 1'b0;
    end
  end

  assign in_i.ready            = in_ready;
  assign out_o.valid           = out_vq;
  assign out_o.out_power       = out_pow_q;
  assign out_o.out_coefficient = out_coef_q;
  assign out_o.last_term       = out_last_q;
  assign out_o.empty_product   = out_empty_q;
  assign out_o.terms_dropped   = out_drop_q;

`ifndef SYNTH
  a_issue_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ISSUE) |-> (a_cnt_q != '0 && b_cnt_q != '0))
    else $error("pair issue with an empty store");

  a_exit_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[PRODUCT_TERMS].valid |-> ent[PRODUCT_TERMS].valid)
    else $error("product left the chain while a cell was free");

  a_drain_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> !tok[0].valid)
    else $error("product entered the chain during drain");

  a_empty_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vq && out_empty_q) |-> (out_coef_q == '0 && out_pow_q == '0 && !out_last_q))
    else $error("empty result carries data");
`endif

endmodule

// ===== verif/testbench.sv =====
// testbench: self-checking bench for sparse_polynomial_multiply; loads random sparse
// polynomials, multiplies them and checks every result term against its own product model.
// Depends on sppm_pkg, sppm_if.sv and the design top level.
module testbench;
  import sppm_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 320;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 2000000;

  typedef struct packed {
    logic [OUT_POW_W-1:0]         power;
    logic signed [OUT_COEF_W-1:0] coef;
    logic                         last;
    logic                         empty;
    logic                         dropped;
  } result_term_t;

  class product_checker;
    logic [TERM_POW_W-1:0]         first_pow [FIRST_TERMS];
    logic signed [TERM_COEF_W-1:0] first_coef [FIRST_TERMS];
    logic [TERM_POW_W-1:0]         second_pow [SECOND_TERMS];
    logic signed [TERM_COEF_W-1:0] second_coef [SECOND_TERMS];
    int                            first_count;
    int                            second_count;
    bit                            overflow_seen;
    result_term_t                  expected_terms[$];
    int                            errors;
    int                            terms_checked;
    int                            multiplies;
    int                            empty_seen;
    int                            dropped_seen;

    function void clear_stores();
      first_count   = 0;
      second_count  = 0;
      overflow_seen = 0;
    endfunction

    function void predict_product();
      logic [OUT_POW_W-1:0]         tab_pow [PRODUCT_TERMS];
      logic signed [OUT_COEF_W-1:0] tab_coef [PRODUCT_TERMS];
      logic [OUT_POW_W-1:0]         p;
      logic signed [OUT_COEF_W-1:0] c;
      result_term_t                 r;
      int                           used;
      bit                           hit;
      multiplies++;
      r = '0;
      if (first_count == 0 || second_count == 0) begin
        r.empty = 1'b1;
        expected_terms.push_back(r);
        clear_stores();
        return;
      end
      used = 0;
      for (int i = 0; i < first_count; i++) begin
        for (int j = 0; j < second_count; j++) begin
          p = OUT_POW_W'(first_pow[i]) + OUT_POW_W'(second_pow[j]);
          c = first_coef[i];
          c = c * second_coef[j];
          hit = 0;
          for (int k = 0; k < used; k++) begin
            if (!hit && tab_pow[k] == p) begin
              tab_coef[k] = tab_coef[k] + c;
              hit = 1;
            end
          end
          if (!hit) begin
            if (used < PRODUCT_TERMS) begin
              tab_pow[used]  = p;
              tab_coef[used] = c;
              used++;
            end else begin
              overflow_seen = 1;
            end
          end
        end
      end
      for (int k = used - 1; k >= 0; k--) begin
        r.power   = tab_pow[k];
        r.coef    = tab_coef[k];
        r.last    = (k == 0);
        r.empty   = 1'b0;
        r.dropped = overflow_seen;
        expected_terms.push_back(r);
      end
      clear_stores();
    endfunction

    function void note_request(logic [OPCODE_W-1:0] op, logic [TERM_POW_W-1:0] pw,
                               logic signed [TERM_COEF_W-1:0] cf);
      case (op)
        OP_LOAD_FIRST: begin
          if (first_count < FIRST_TERMS) begin
            first_pow[first_count]  = pw;
            first_coef[first_count] = cf;
            first_count++;
          end else begin
            overflow_seen = 1;
          end
        end
        OP_LOAD_SECOND: begin
          if (second_count < SECOND_TERMS) begin
            second_pow[second_count]  = pw;
            second_coef[second_count] = cf;
            second_count++;
          end else begin
            overflow_seen = 1;
          end
        end
        OP_MULTIPLY: predict_product();
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_term(result_term_t got);
      result_term_t exp;
      if (expected_terms.size() == 0) begin
        report($sformatf("result term power %0d coef %0d with nothing expected",
                         got.power, got.coef));
        return;
      end
      exp = expected_terms.pop_front();
      terms_checked++;
      if (got.empty) empty_seen++;
      if (got.dropped) dropped_seen++;
      if (got.power !== exp.power)
        report($sformatf("term %0d power got %0d exp %0d", terms_checked, got.power, exp.power));
      if (got.coef !== exp.coef)
        report($sformatf("term %0d coef got %0d exp %0d", terms_checked, got.coef, exp.coef));
      if (got.last !== exp.last)
        report($sformatf("term %0d last got %0b exp %0b", terms_checked, got.last, exp.last));
      if (got.empty !== exp.empty)
        report($sformatf("term %0d empty got %0b exp %0b", terms_checked, got.empty, exp.empty));
      if (got.dropped !== exp.dropped)
        report($sformatf("term %0d dropped got %0b exp %0b", terms_checked, got.dropped,
                         exp.dropped));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  sppm_in_if  in_if ();
  sppm_out_if out_if ();

  sparse_polynomial_multiply dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  product_checker board = new();
  int             requests_sent;
  int             burst_left;
  int             cycles;
  bit             long_hold_done;
  result_term_t   seen_term;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d terms outstanding", cycles,
               board.expected_terms.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // results are checked before a request at the same edge is noted
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      seen_term.power   = out_if.out_power;
      seen_term.coef    = out_if.out_coefficient;
      seen_term.last    = out_if.last_term;
      seen_term.empty   = out_if.empty_product;
      seen_term.dropped = out_if.terms_dropped;
      board.check_term(seen_term);
    end
    if (rst_ni && in_if.valid && in_if.ready)
      board.note_request(in_if.opcode, in_if.term_power, in_if.term_coefficient);
  end

  // receiver stall pattern, with one long hold-off once results are flowing
  initial begin
    int mode;
    int len;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(4, 40);
      if (!long_hold_done && board.terms_checked >= 40) begin
        long_hold_done = 1;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        repeat (len) begin
          case (mode)
            0: out_if.ready <= 1'b1;
            1: out_if.ready <= ($urandom_range(0, 1) == 0);
            2: out_if.ready <= ($urandom_range(0, 3) == 0);
            default: out_if.ready <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  task send_request(input logic [OPCODE_W-1:0] op, input logic [TERM_POW_W-1:0] pw,
                    input logic signed [TERM_COEF_W-1:0] cf);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_if.valid            <= 1'b1;
    in_if.opcode           <= op;
    in_if.term_power       <= pw;
    in_if.term_coefficient <= cf;
    do @(posedge clk_i); while (!in_if.ready);
    if (op != OP_UNUSED) requests_sent++;
  endtask

  function automatic logic signed [TERM_COEF_W-1:0] pick_coef();
    if ($urandom_range(0, 3) != 0) return TERM_COEF_W'($urandom);
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return 16'h0001;
    endcase
  endfunction

  // loads two polynomials in random interleave, then multiplies
  task send_random_product();
    int  na;
    int  nb;
    int  ia;
    int  ib;
    int  style;
    int  base;
    int  sel;
    bit  to_first;
    logic [TERM_POW_W-1:0] pw;
    sel = $urandom_range(0, 19);
    na  = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(9, 11) : $urandom_range(1, 8);
    sel = $urandom_range(0, 19);
    nb  = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(9, 11) : $urandom_range(1, 8);
    style = $urandom_range(0, 2);
    base  = $urandom_range(0, 40);
    ia = 0;
    ib = 0;
    while (ia < na || ib < nb) begin
      to_first = (ib >= nb) || ((ia < na) && ($urandom_range(0, 1) == 0));
      case (style)
        0: pw = TERM_POW_W'($urandom_range(0, 127));
        1: pw = TERM_POW_W'($urandom_range(0, 3));
        default: pw = to_first ? TERM_POW_W'(base + ia) : TERM_POW_W'(8 * ib);
      endcase
      if (to_first) begin
        send_request(OP_LOAD_FIRST, pw, pick_coef());
        ia++;
      end else begin
        send_request(OP_LOAD_SECOND, pw, pick_coef());
        ib++;
      end
      if ($urandom_range(0, 19) == 0)
        send_request(OP_UNUSED, TERM_POW_W'($urandom), TERM_COEF_W'($urandom));
    end
    send_request(OP_MULTIPLY, TERM_POW_W'($urandom), TERM_COEF_W'($urandom));
  endtask

  initial begin
    int n;
    rst_ni                 <= 1'b0;
    in_if.valid            <= 1'b0;
    in_if.opcode           <= OP_LOAD_FIRST;
    in_if.term_power       <= '0;
    in_if.term_coefficient <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty product, then one side only
    send_request(OP_MULTIPLY, 7'd0, 16'h0000);
    send_request(OP_LOAD_FIRST, 7'd127, 16'h7fff);
    send_request(OP_MULTIPLY, 7'd127, 16'hffff);
    // field extremes
    send_request(OP_LOAD_FIRST, 7'd127, 16'h8000);
    send_request(OP_LOAD_FIRST, 7'd0, 16'h7fff);
    send_request(OP_LOAD_SECOND, 7'd127, 16'h8000);
    send_request(OP_LOAD_SECOND, 7'd0, 16'hffff);
    send_request(OP_MULTIPLY, 7'd0, 16'h0000);
    // sum cancels to zero, with an ignored opcode inside
    send_request(OP_LOAD_FIRST, 7'd1, 16'h0001);
    send_request(OP_LOAD_FIRST, 7'd2, 16'h0001);
    send_request(OP_UNUSED, 7'h55, 16'h5a5a);
    send_request(OP_LOAD_SECOND, 7'd1, 16'h0001);
    send_request(OP_LOAD_SECOND, 7'd0, 16'hffff);
    send_request(OP_MULTIPLY, 7'h2a, 16'ha5a5);
    // first store overflows
    for (int i = 0; i < FIRST_TERMS + 1; i++)
      send_request(OP_LOAD_FIRST, TERM_POW_W'(3 * i), pick_coef());
    send_request(OP_LOAD_SECOND, 7'd5, 16'h0003);
    send_request(OP_MULTIPLY, 7'd0, 16'h0000);

    while (requests_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 6) == 0) begin
        n = $urandom_range(1, 4);
        repeat (n) send_request(OPCODE_W'($urandom_range(0, 3)), TERM_POW_W'($urandom),
                                TERM_COEF_W'($urandom));
      end else begin
        send_random_product();
      end
    end
    // close any partial sequence so the last loads produce results too
    send_request(OP_MULTIPLY, 7'd0, 16'h0000);
    in_if.valid <= 1'b0;

    while (board.expected_terms.size() != 0) @(posedge clk_i);
    repeat (2 * PRODUCT_TERMS + 16) @(posedge clk_i);

    $display("requests %0d, multiplies %0d, result terms %0d checked", requests_sent,
             board.multiplies, board.terms_checked);
    $display("empty products %0d, terms flagged dropped %0d, long output hold %0s",
             board.empty_seen, board.dropped_seen, long_hold_done ? "done" : "not reached");
    if (board.errors == 0 && board.expected_terms.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d terms outstanding", board.errors,
               board.expected_terms.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
